// ===== hw/rtl/fpw_pkg.sv =====
// fpw_pkg: types, codes and constants shared by the four-level page walker
// used by fpw_if.sv, fpw_cache.sv and four_level_page_walker.sv
`default_nettype none

package fpw_pkg;

  // fixed field widths
  localparam int unsigned VA_BITS   = 48;
  localparam int unsigned REG_BITS  = 52;
  localparam int unsigned DATA_BITS = 64;
  localparam int unsigned IDX_BITS  = 9;
  localparam int unsigned TOP_SHIFT = 39;

  // entry bits
  localparam int unsigned PRESENT_BIT = 0;
  localparam int unsigned LARGE_BIT   = 7;

  // table base ignores its low four bits
  localparam logic [REG_BITS-1:0] BASE_KEEP_MASK = ~REG_BITS'(4'hf);

  // configuration register reset values
  localparam logic [REG_BITS-1:0] TABLE_BASE_RST = '0;
  localparam logic [REG_BITS-1:0] FRAME_MASK_RST = 52'hFFFFFFFFFF000;

  // parameter defaults
  localparam int unsigned CACHE_ENTRIES_DEF  = 512;
  localparam int unsigned PHYS_ADDR_BITS_DEF = 52;

  typedef enum logic [0:0] {
    REG_TABLE_BASE = 1'b0,
    REG_FRAME_MASK = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_XLATE = 1'b0,
    CMD_RESP  = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    KIND_READ = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    STATUS_OK    = 1'b0,
    STATUS_FAULT = 1'b1
  } status_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef logic [1:0] level_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fpw_if.sv =====
// fpw_in_if / fpw_out_if: valid-ready channels of the page walker
// depends on fpw_pkg for field widths
`default_nettype none

interface fpw_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic [fpw_pkg::VA_BITS-1:0]      virt_addr;
  logic [fpw_pkg::DATA_BITS-1:0]    read_data;

  modport source (output valid, output cmd, output virt_addr, output read_data,
                  input ready);
  modport sink   (input valid, input cmd, input virt_addr, input read_data,
                  output ready);
endinterface

interface fpw_out_if;
  logic                             valid;
  logic                             ready;
  logic                             kind;
  logic [fpw_pkg::REG_BITS-1:0]     mem_addr;
  logic                             status;
  logic [fpw_pkg::REG_BITS-1:0]     phys_addr;

  modport source (output valid, output kind, output mem_addr, output status,
                  output phys_addr, input ready);
  modport sink   (input valid, input kind, input mem_addr, input status,
                  input phys_addr, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fpw_cache.sv =====
// fpw_cache: direct-mapped store of top-level entries (tag and entry memories)
// clears itself to zero after reset, one slot per cycle; depends on fpw_pkg
`default_nettype none

module fpw_cache #(
  parameter int unsigned CACHE_ENTRIES  = fpw_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned PHYS_ADDR_BITS = fpw_pkg::PHYS_ADDR_BITS_DEF,
  localparam int unsigned IdxW = $clog2(CACHE_ENTRIES)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  output logic                                clr_busy_o,
  input  wire logic                           rd_en_i,
  input  wire logic [IdxW-1:0]                rd_idx_i,
  output logic [PHYS_ADDR_BITS-1:0]           rd_tag_o,
  output logic [fpw_pkg::DATA_BITS-1:0]       rd_entry_o,
  input  wire logic                           wr_en_i,
  input  wire logic [IdxW-1:0]                wr_idx_i,
  input  wire logic [PHYS_ADDR_BITS-1:0]      wr_tag_i,
  input  wire logic [fpw_pkg::DATA_BITS-1:0]  wr_entry_i
);

  logic [PHYS_ADDR_BITS-1:0]     tag_mem   [CACHE_ENTRIES];
  logic [fpw_pkg::DATA_BITS-1:0] entry_mem [CACHE_ENTRIES];

  logic                          clr_busy_q, clr_busy_d;
  logic [IdxW-1:0]               clr_cnt_q, clr_cnt_d;

  logic                          we;
  logic [IdxW-1:0]               widx;
  logic [PHYS_ADDR_BITS-1:0]     wtag;
  logic [fpw_pkg::DATA_BITS-1:0] wentry;

  // clearing sweep after reset
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + IdxW'(1);
      if (clr_cnt_q == IdxW'(CACHE_ENTRIES - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  assign clr_busy_o = clr_busy_q;

  // write port: sweep has priority
  always_comb begin
    we     = clr_busy_q | wr_en_i;
    widx   = clr_busy_q ? clr_cnt_q : wr_idx_i;
    wtag   = clr_busy_q ? '0 : wr_tag_i;
    wentry = clr_busy_q ? '0 : wr_entry_i;
  end

  // memories, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      tag_mem[widx]   <= wtag;
      entry_mem[widx] <= wentry;
    end
    if (rd_en_i) begin
      rd_tag_o   <= tag_mem[rd_idx_i];
      rd_entry_o <= entry_mem[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_walker.sv =====
// four_level_page_walker: top level of the four-level page table walker
// depends on fpw_pkg, fpw_in_if / fpw_out_if and fpw_cache
`default_nettype none

// Walks four-level page tables for 48-bit virtual addresses. Each input word is
// either a translation request or a memory read response; each produces at most
// one output word: a read request for the next table entry, or a finished
// translation with status and physical address. Top-level entries are kept in a
// direct-mapped cache in synchronous memory, tagged by entry address. Each word
// is accepted in the idle state (the cache being read for a request), then is
// evaluated in the execute state against the registered cache data and loads the
// output register; a result still waiting there stalls the execute state only,
// and no new word is taken before it ends. After reset the cache is zeroed, one
// slot per cycle; during the sweep no input word is taken, config writes are.

module four_level_page_walker #(
  parameter int unsigned CACHE_ENTRIES  = fpw_pkg::CACHE_ENTRIES_DEF,
  parameter int unsigned PHYS_ADDR_BITS = fpw_pkg::PHYS_ADDR_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [fpw_pkg::REG_BITS-1:0]  cfg_data_i,
  fpw_in_if.sink                             in_i,
  fpw_out_if.source                          out_o
);

  localparam int unsigned IdxW = $clog2(CACHE_ENTRIES);
  localparam int unsigned RegW = fpw_pkg::REG_BITS;
  localparam logic [RegW-1:0] PaMask = RegW'((65'd1 << PHYS_ADDR_BITS) - 65'd1);

  // configuration
  logic [RegW-1:0] table_base_q, frame_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= fpw_pkg::TABLE_BASE_RST;
      frame_mask_q <= fpw_pkg::FRAME_MASK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fpw_pkg::REG_TABLE_BASE: table_base_q <= cfg_data_i;
        fpw_pkg::REG_FRAME_MASK: frame_mask_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control and walk state
  fpw_pkg::state_e state_q, state_d;
  fpw_pkg::level_t walk_level_q, walk_level_d;
  logic            busy_q, busy_d;
  logic [fpw_pkg::VA_BITS-1:0] pending_va_q, pending_va_d;

  // registered input word
  logic                          item_cmd_q;
  logic [fpw_pkg::VA_BITS-1:0]   item_va_q;
  logic [fpw_pkg::DATA_BITS-1:0] item_data_q;

  // output register
  logic            out_valid_q, out_valid_d;
  logic            out_kind_q, out_status_q;
  logic [RegW-1:0] out_mem_q, out_phys_q;

  // cache
  logic                          clr_busy;
  logic                          rd_en;
  logic [PHYS_ADDR_BITS-1:0]     c_tag;
  logic [fpw_pkg::DATA_BITS-1:0] c_entry;
  logic                          c_we;
  logic [IdxW-1:0]               c_widx;

  logic in_fire, advance;

  assign in_i.ready = (state_q == fpw_pkg::ST_IDLE) && !clr_busy;
  assign in_fire    = in_i.valid && in_i.ready;
  assign advance    = (state_q == fpw_pkg::ST_EXEC) && (!out_valid_q || out_o.ready);
  assign rd_en      = in_fire && (in_i.cmd == fpw_pkg::CMD_XLATE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpw_pkg::ST_IDLE: if (in_fire) state_d = fpw_pkg::ST_EXEC;
      fpw_pkg::ST_EXEC: if (advance) state_d = fpw_pkg::ST_IDLE;
      default: state_d = fpw_pkg::ST_IDLE;
    endcase
  end

  // evaluation of the registered word
  logic                          is_req;
  logic [fpw_pkg::VA_BITS-1:0]   va;
  logic [RegW-1:0]               top_addr;
  logic                          hit;
  logic [fpw_pkg::DATA_BITS-1:0] entry;
  fpw_pkg::level_t               level;
  logic [RegW-1:0]               frame;
  logic [RegW-1:0]               addend;
  logic [RegW-1:0]               sum;
  logic                          present, big_page;

  always_comb begin
    is_req   = (item_cmd_q == fpw_pkg::CMD_XLATE);
    va       = is_req ? item_va_q : pending_va_q;
    top_addr = ((table_base_q & fpw_pkg::BASE_KEEP_MASK)
               + RegW'({va[47:39], 3'b000})) & PaMask;
    hit      = (RegW'(c_tag) == top_addr);
    entry    = is_req ? c_entry : item_data_q;
    level    = is_req ? 2'd0 : walk_level_q;
    frame    = entry[RegW-1:0] & frame_mask_q;
    present  = entry[fpw_pkg::PRESENT_BIT];
    big_page = entry[fpw_pkg::LARGE_BIT];
    case (level)
      2'd0:    addend = RegW'({va[38:30], 3'b000});
      2'd1:    addend = big_page ? RegW'(va[29:0]) : RegW'({va[29:21], 3'b000});
      2'd2:    addend = big_page ? RegW'(va[20:0]) : RegW'({va[20:12], 3'b000});
      default: addend = RegW'(va[11:0]);
    endcase
    sum = (frame + addend) & PaMask;
  end

  // outputs and state updates of the walk step
  logic            emit;
  logic            res_kind, res_status;
  logic [RegW-1:0] res_mem, res_phys;

  always_comb begin
    emit         = 1'b0;
    res_kind     = fpw_pkg::KIND_READ;
    res_status   = fpw_pkg::STATUS_OK;
    res_mem      = '0;
    res_phys     = '0;
    walk_level_d = walk_level_q;
    busy_d       = busy_q;
    pending_va_d = is_req ? item_va_q : pending_va_q;

    if (is_req && !hit) begin
      // miss: fetch the top-level entry
      emit         = 1'b1;
      res_mem      = top_addr;
      walk_level_d = 2'd0;
      busy_d       = 1'b1;
    end else if (!is_req && !busy_q) begin
      // stray response: dropped
      emit = 1'b0;
    end else begin
      emit = 1'b1;
      if (level == 2'd3) begin
        res_kind     = fpw_pkg::KIND_DONE;
        res_status   = (frame == '0) ? fpw_pkg::STATUS_FAULT : fpw_pkg::STATUS_OK;
        res_phys     = (frame == '0) ? '0 : sum;
        walk_level_d = 2'd0;
        busy_d       = 1'b0;
      end else if (!present) begin
        res_kind     = fpw_pkg::KIND_DONE;
        res_status   = fpw_pkg::STATUS_FAULT;
        walk_level_d = 2'd0;
        busy_d       = 1'b0;
      end else if (big_page && (level == 2'd1 || level == 2'd2)) begin
        res_kind     = fpw_pkg::KIND_DONE;
        res_phys     = sum;
        walk_level_d = 2'd0;
        busy_d       = 1'b0;
      end else begin
        res_mem      = sum;
        walk_level_d = level + 2'd1;
        busy_d       = 1'b1;
      end
    end
  end

  // cache fill on a top-level response, present or not
  assign c_we   = advance && !is_req && busy_q && (walk_level_q == 2'd0);
  assign c_widx = pending_va_q[fpw_pkg::TOP_SHIFT +: IdxW];

  fpw_cache #(
    .CACHE_ENTRIES  (CACHE_ENTRIES),
    .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
  ) u_cache (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_busy_o (clr_busy),
    .rd_en_i    (rd_en),
    .rd_idx_i   (in_i.virt_addr[fpw_pkg::TOP_SHIFT +: IdxW]),
    .rd_tag_o   (c_tag),
    .rd_entry_o (c_entry),
    .wr_en_i    (c_we),
    .wr_idx_i   (c_widx),
    .wr_tag_i   (top_addr[PHYS_ADDR_BITS-1:0]),
    .wr_entry_i (item_data_q)
  );

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (advance && emit) out_valid_d = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= fpw_pkg::ST_IDLE;
      walk_level_q <= 2'd0;
      busy_q       <= 1'b0;
      pending_va_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        walk_level_q <= walk_level_d;
        busy_q       <= busy_d;
        pending_va_q <= pending_va_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_cmd_q  <= in_i.cmd;
      item_va_q   <= in_i.virt_addr;
      item_data_q <= in_i.read_data;
    end
    if (advance && emit) begin
      out_kind_q   <= res_kind;
      out_status_q <= res_status;
      out_mem_q    <= res_mem;
      out_phys_q   <= res_phys;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.status    = out_status_q;
  assign out_o.mem_addr  = out_mem_q;
  assign out_o.phys_addr = out_phys_q;

endmodule

`default_nettype wire
